/* sv/dpa_pkg.sv */
// shared types and constants for the partition allocator
// used by dpa_cell and the top level
package dpa_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_NOOWNER = 3'd2,
        ST_FULL    = 3'd3,
        ST_ZERO    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NONE  = 2'd3
    } fit_t;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_FIT_POLICY  = 1'b0,
        REG_MEMORY_SIZE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_DONE
    } state_t;

    // per-cell command, applied by every cell in the same cycle
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ROTATE,
        CMD_INIT,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_WRITE
    } cmd_t;

    localparam int unsigned ADDR_BITS = 20;
    localparam int unsigned LEN_W     = ADDR_BITS + 1;
    localparam int unsigned OWNER_W   = 16;
    localparam int unsigned OUT_W     = ADDR_BITS;

endpackage

/* sv/dpa_cell.sv */
// one table entry of the partition allocator chain
// depends on dpa_pkg; neighbors are wired by the top level
module dpa_cell
    import dpa_pkg::*;
#(
    parameter int unsigned IDX_W     = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [IDX_W-1:0]     my_idx,
    input  logic [IDX_W-1:0]     sel_idx,
    input  logic [LEN_W-1:0]     init_len,
    input  logic                 is_head,
    // neighbor below (index - 1) and above (index + 1)
    input  logic [ADDR_BITS-1:0] prev_start,
    input  logic [LEN_W-1:0]     prev_len,
    input  logic                 prev_busy,
    input  logic [OWNER_W-1:0]   prev_owner,
    input  logic [ADDR_BITS-1:0] next_start,
    input  logic [LEN_W-1:0]     next_len,
    input  logic                 next_busy,
    input  logic [OWNER_W-1:0]   next_owner,
    // write data for the selected cell and for an inserted cell
    input  logic [ADDR_BITS-1:0] wr_start,
    input  logic [LEN_W-1:0]     wr_len,
    input  logic                 wr_busy,
    input  logic [OWNER_W-1:0]   wr_owner,
    output logic [ADDR_BITS-1:0] start,
    output logic [LEN_W-1:0]     len,
    output logic                 busy,
    output logic [OWNER_W-1:0]   owner
);

    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 busy_reg, busy_next;
    logic [OWNER_W-1:0]   owner_reg, owner_next;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        busy_next  = busy_reg;
        owner_next = owner_reg;
        unique case (cmd)
            CMD_ROTATE:
            begin
                // shift toward index zero, head wraps around
                start_next = next_start;
                len_next   = next_len;
                busy_next  = next_busy;
                owner_next = next_owner;
            end
            CMD_INIT:
            begin
                start_next = '0;
                len_next   = is_head ? init_len : '0;
                busy_next  = 1'b0;
                owner_next = '0;
            end
            CMD_INSERT:
            begin
                if (my_idx > sel_idx + IDX_W'(1))
                begin
                    start_next = prev_start;
                    len_next   = prev_len;
                    busy_next  = prev_busy;
                    owner_next = prev_owner;
                end
                else if (my_idx == sel_idx + IDX_W'(1))
                begin
                    start_next = wr_start;
                    len_next   = wr_len;
                    busy_next  = 1'b0;
                    owner_next = '0;
                end
            end
            CMD_REMOVE:
            begin
                if (my_idx >= sel_idx)
                begin
                    start_next = next_start;
                    len_next   = next_len;
                    busy_next  = next_busy;
                    owner_next = next_owner;
                end
            end
            CMD_WRITE:
            begin
                if (my_idx == sel_idx)
                begin
                    start_next = wr_start;
                    len_next   = wr_len;
                    busy_next  = wr_busy;
                    owner_next = wr_owner;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= is_head ? LEN_W'(1) << ADDR_BITS : '0;
            busy_reg  <= 1'b0;
            owner_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
            busy_reg  <= busy_next;
            owner_reg <= owner_next;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;
    assign busy  = busy_reg;
    assign owner = owner_reg;

endmodule

/* sv/dynamic_partition_allocator_unit.sv */
// Partition allocator: an address-ordered table of MAX_ENTRIES partitions held in
// a chain of cells. A request rotates the whole chain once past cell zero to scan
// for a fit or an owner. An allocate then splits or marks the picked entry in
// S_ALLOC and does the final entry write in S_DONE; a free merges with the next
// and then the previous entry in S_FREE_NEXT and S_FREE_PREV and writes the
// merged entry in S_DONE. No fit or owner not found answers straight after the
// scan, and a zero size answers without a scan. Writing memory_size reinitializes
// the table. One request is in work at a time; its result waits in an output
// register and the next request is taken the cycle after it is delivered.
module dynamic_partition_allocator_unit
    import dpa_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [OWNER_W-1:0]   owner_id,
    input  logic [LEN_W-1:0]     request_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [OUT_W-1:0]     base_address
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(1) << ADDR_BITS;

    logic [ADDR_BITS-1:0] c_start [MAX_ENTRIES];
    logic [LEN_W-1:0]     c_len   [MAX_ENTRIES];
    logic                 c_busy  [MAX_ENTRIES];
    logic [OWNER_W-1:0]   c_owner [MAX_ENTRIES];

    state_t state_reg, state_next;
    cmd_t   cmd;
    logic [1:0]       fit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_reg;
    logic             found_reg;
    logic [IDX_W-1:0] pick_reg;
    logic [LEN_W-1:0] pick_len_reg;
    logic             op_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [LEN_W-1:0] size_reg;
    logic [2:0]       status_reg;
    logic [OUT_W-1:0] base_reg;
    logic [IDX_W-1:0] sel_idx;
    logic [ADDR_BITS-1:0] wr_start;
    logic [LEN_W-1:0] wr_len, init_len;
    logic             wr_busy;
    logic [OWNER_W-1:0] wr_owner;
    logic             cand, better, scan_last;
    logic [IDX_W-1:0] pick_p1, pick_m1;

    // merges accumulate length into the survivor with a registered write
    logic             merge_wr_reg;
    logic [IDX_W-1:0] merge_idx_reg;
    logic [LEN_W-1:0] merge_len_reg;
    logic             split_wr_reg;

    logic                 late_wr;
    logic [IDX_W-1:0]     late_idx;
    logic [ADDR_BITS-1:0] late_start;
    logic [LEN_W-1:0]     late_len;
    logic                 late_busy;
    logic [OWNER_W-1:0]   late_owner;

    assign init_len = (cfg_data > CAP) ? CAP : cfg_data;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            localparam int unsigned PV = (g == 0) ? MAX_ENTRIES - 1 : g - 1;
            localparam int unsigned NX = (g == MAX_ENTRIES - 1) ? 0 : g + 1;
            dpa_cell #(.IDX_W(IDX_W)) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .my_idx(IDX_W'(g)), .sel_idx(sel_idx), .init_len(init_len),
                .is_head(g == 0),
                .prev_start(c_start[PV]), .prev_len(c_len[PV]),
                .prev_busy(c_busy[PV]), .prev_owner(c_owner[PV]),
                .next_start(c_start[NX]), .next_len(c_len[NX]),
                .next_busy(c_busy[NX]), .next_owner(c_owner[NX]),
                .wr_start(wr_start), .wr_len(wr_len), .wr_busy(wr_busy),
                .wr_owner(wr_owner),
                .start(c_start[g]), .len(c_len[g]), .busy(c_busy[g]),
                .owner(c_owner[g])
            );
        end
    endgenerate

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign scan_last = (scan_reg == IDX_W'(MAX_ENTRIES - 1));
    assign pick_p1   = pick_reg + IDX_W'(1);
    assign pick_m1   = pick_reg - IDX_W'(1);

    // cell zero holds entry scan_reg during the rotation
    always_comb
    begin
        cand   = 1'b0;
        better = 1'b0;
        if ({1'b0, scan_reg} < (CNT_W+1)'(count_reg))
        begin
            if (op_reg == OP_ALLOC)
                cand = !c_busy[0] && c_len[0] >= size_reg;
            else
                cand = c_busy[0] && c_owner[0] == owner_reg;
        end
        if (cand)
        begin
            if (!found_reg)
                better = 1'b1;
            else if (op_reg == OP_ALLOC && fit_reg == FIT_BEST)
                better = c_len[0] < pick_len_reg;
            else if (op_reg == OP_ALLOC && fit_reg == FIT_WORST)
                better = c_len[0] > pick_len_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                    state_next = (op == OP_ALLOC && request_size == '0) ? S_DONE : S_SCAN;
            S_SCAN:
                if (scan_last)
                    state_next = !found_reg && !better ? S_DONE
                               : (op_reg == OP_ALLOC) ? S_ALLOC : S_FREE_NEXT;
            S_ALLOC:     state_next = S_DONE;
            S_FREE_NEXT: state_next = S_FREE_PREV;
            S_FREE_PREV: state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // final write of the split or merged entry, issued in S_DONE
    always_comb
    begin
        late_wr    = merge_wr_reg || split_wr_reg;
        late_idx   = merge_wr_reg ? merge_idx_reg : pick_reg;
        late_start = c_start[late_idx];
        late_len   = merge_wr_reg ? merge_len_reg : size_reg;
        late_busy  = split_wr_reg;
        late_owner = split_wr_reg ? owner_reg : '0;
    end

    always_comb
    begin
        cmd        = CMD_HOLD;
        sel_idx    = pick_reg;
        wr_start   = c_start[pick_reg];
        wr_len     = c_len[pick_reg];
        wr_busy    = c_busy[pick_reg];
        wr_owner   = c_owner[pick_reg];
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
                if (cfg_valid && cfg_index == REG_MEMORY_SIZE)
                begin
                    cmd        = CMD_INIT;
                    count_next = CNT_W'(1);
                end
            S_SCAN:
                cmd = CMD_ROTATE;
            S_ALLOC:
                if (c_len[pick_reg] == size_reg)
                begin
                    cmd      = CMD_WRITE;
                    wr_busy  = 1'b1;
                    wr_owner = owner_reg;
                end
                else if ({1'b0, count_reg} < (CNT_W+1)'(MAX_ENTRIES))
                begin
                    // split: new free entry after pick, pick itself written next cycle
                    cmd        = CMD_INSERT;
                    wr_start   = c_start[pick_reg] + ADDR_BITS'(size_reg);
                    wr_len     = c_len[pick_reg] - size_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            S_FREE_NEXT:
            begin
                if ({1'b0, pick_reg} + (IDX_W+1)'(1) < (IDX_W+1)'(count_reg)
                    && !c_busy[pick_p1])
                begin
                    cmd        = CMD_REMOVE;
                    sel_idx    = pick_p1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_FREE_PREV:
            begin
                if (pick_reg != '0 && !c_busy[pick_m1])
                begin
                    cmd        = CMD_REMOVE;
                    sel_idx    = pick_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (late_wr)
                begin
                    cmd      = CMD_WRITE;
                    sel_idx  = late_idx;
                    wr_start = late_start;
                    wr_len   = late_len;
                    wr_busy  = late_busy;
                    wr_owner = late_owner;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fit_reg    <= FIT_FIRST;
            count_reg  <= CNT_W'(1);
            scan_reg   <= '0;
            found_reg  <= 1'b0;
            out_valid  <= 1'b0;
            merge_wr_reg <= 1'b0;
            split_wr_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            merge_wr_reg <= (state_reg == S_FREE_PREV);
            split_wr_reg <= (cmd == CMD_INSERT);
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_valid && cfg_ready && cfg_index == REG_FIT_POLICY)
                fit_reg <= cfg_data[1:0];
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + IDX_W'(1);
                    if (better)
                        found_reg <= 1'b1;
                end
                S_DONE:
                    out_valid <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // payload and the pick tracking
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    op_reg     <= op;
                    owner_reg  <= owner_id;
                    size_reg   <= request_size;
                    status_reg <= ST_ZERO;
                    base_reg   <= '0;
                end
            S_SCAN:
            begin
                if (better)
                begin
                    pick_reg     <= scan_reg;
                    pick_len_reg <= c_len[0];
                end
                if (scan_last && !found_reg && !better)
                begin
                    status_reg <= (op_reg == OP_ALLOC) ? ST_NOFIT : ST_NOOWNER;
                    base_reg   <= '0;
                end
            end
            S_ALLOC:
            begin
                if (c_len[pick_reg] != size_reg
                    && {1'b0, count_reg} >= (CNT_W+1)'(MAX_ENTRIES))
                begin
                    status_reg <= ST_FULL;
                    base_reg   <= '0;
                end
                else
                begin
                    status_reg <= ST_OK;
                    base_reg   <= OUT_W'(c_start[pick_reg]);
                end
            end
            S_FREE_NEXT:
            begin
                status_reg    <= ST_OK;
                base_reg      <= OUT_W'(c_start[pick_reg]);
                merge_len_reg <= (cmd == CMD_REMOVE) ? c_len[pick_reg] + c_len[pick_p1]
                                                     : c_len[pick_reg];
            end
            S_FREE_PREV:
            begin
                merge_idx_reg <= (cmd == CMD_REMOVE) ? pick_m1 : pick_reg;
                merge_len_reg <= (cmd == CMD_REMOVE) ? c_len[pick_m1] + merge_len_reg
                                                     : merge_len_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status       = status_reg;
    assign base_address = base_reg;

endmodule
